>>> rtl/rmth_pkg.sv
package rmth_pkg;

    localparam int MAX_SAMPLES_DEF = 2048;
    localparam int SAMPLE_W        = 32;
    localparam int TOTAL_W         = 12;

    // action codes carried on the input tuser
    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // heap walk sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PUSH_RD,
        ST_PUSH_CMP,
        ST_DN_LEFT,
        ST_DN_RIGHT,
        ST_DN_CMP,
        ST_MEDIAN,
        ST_OUT
    } t_state;

endpackage

>>> rtl/rmth_heap_ram.sv
module rmth_heap_ram
    import rmth_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                i_clk,
    input  logic                i_wr,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [SAMPLE_W-1:0] i_wr_data,
    input  logic                i_rd,
    input  logic [AW-1:0]       i_rd_addr,
    output logic [SAMPLE_W-1:0] o_rd_data
);

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/running_median_two_heaps.sv
// Running lower median over a stream of signed 32-bit samples, kept in two binary heaps held
// in RAMs with a registered read: a max-heap with the smaller floor((n-1)/2) samples and a
// min-heap whose top is the median. On the slave side tuser selects push (0) or clear (1)
// and tdata carries the sample; every slave beat gives one master beat with the median, the
// sample count and a flag for a push dropped because the store is full. Items are worked one
// at a time: a decide step, then a sift-up insert that reads and compares at each heap level
// and, when a top has to cross to the other heap, a sift-down replace of that heap's top
// that reads the left child, reads the right child and compares at each level, then a
// median read and a result load; a clear or a dropped sample goes straight from the decide
// step to the median read. A loaded result waits in the output register while the next beat
// is taken, but the next result waits for it to leave. Only entries below the current heap
// sizes are used, so no clearing pass is needed after reset.
module running_median_two_heaps
    import rmth_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample[31:0]
    input  logic        s_axis_tuser,   // action[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // median_value[31:0], sample_total[43:32], zero fill
    output logic        m_axis_tuser    // dropped[0]
);

    localparam int LO_DEPTH = (MAX_SAMPLES - 1) / 2;
    localparam int UP_DEPTH = MAX_SAMPLES - LO_DEPTH;
    localparam int AW       = $clog2(UP_DEPTH);
    localparam int CW       = $clog2(MAX_SAMPLES + 1);

    t_state r_state, n_state;

    logic [CW-1:0]              r_count;
    logic                       r_action;
    logic signed [SAMPLE_W-1:0] r_x;
    logic                       r_drop;
    // walk registers
    logic                       r_hsel;      // 0 up (min) heap, 1 lo (max) heap
    logic [AW:0]                r_k;         // current index
    logic [AW:0]                r_m;         // heap size during sift-down
    logic signed [SAMPLE_W-1:0] r_v;         // value being placed
    logic signed [SAMPLE_W-1:0] r_l_val;     // left child captured
    logic                       r_rep;       // top replace pending on the other heap
    logic [AW:0]                r_rep_m;     // size of the heap to replace in
    // result register
    logic                       r_out_v;
    logic [SAMPLE_W-1:0]        r_med;
    logic [TOTAL_W-1:0]         r_total;
    logic                       r_res_drop;

    logic [SAMPLE_W-1:0] up_rd_data, lo_rd_data;
    logic                up_rd, lo_rd, up_we, lo_we, hp_we;
    logic [AW-1:0]       raddr, waddr;
    logic [SAMPLE_W-1:0] wdata;

    rmth_heap_ram #(.DEPTH(UP_DEPTH), .AW(AW)) u_up (
        .i_clk    (i_clk),
        .i_wr     (up_we),
        .i_wr_addr(waddr),
        .i_wr_data(wdata),
        .i_rd     (up_rd),
        .i_rd_addr(raddr),
        .o_rd_data(up_rd_data)
    );

    rmth_heap_ram #(.DEPTH(UP_DEPTH), .AW(AW)) u_lo (
        .i_clk    (i_clk),
        .i_wr     (lo_we),
        .i_wr_addr(waddr),
        .i_wr_data(wdata),
        .i_rd     (lo_rd),
        .i_rd_addr(raddr),
        .o_rd_data(lo_rd_data)
    );

    logic signed [SAMPLE_W-1:0] up_top, lo_top, rd;
    logic [AW:0]   parent;
    logic [AW+1:0] lch, rch;
    logic          acc_in, out_free, full, no_l, no_r;
    logic          v_bp, rd_bv, lv_bv, lv_br;
    logic [CW-1:0] lo_sz, up_sz;

    // walk arithmetic and heap order compares
    always_comb begin
        up_top   = up_rd_data;
        lo_top   = lo_rd_data;
        rd       = r_hsel ? lo_rd_data : up_rd_data;
        parent   = (r_k - 1'b1) >> 1;
        lch      = {r_k, 1'b1};
        rch      = lch + 1'b1;
        no_l     = lch >= {1'b0, r_m};
        no_r     = rch >= {1'b0, r_m};
        // moving value before parent value
        v_bp     = r_hsel ? (r_v > rd) : (r_v < rd);
        // read child before moving value
        rd_bv    = r_hsel ? (rd > r_v) : (rd < r_v);
        lv_bv    = r_hsel ? (r_l_val > r_v) : (r_l_val < r_v);
        lv_br    = r_hsel ? (r_l_val > rd) : (r_l_val < rd);
        lo_sz    = (r_count - 1'b1) >> 1;
        up_sz    = r_count - lo_sz;
        full     = r_count >= CW'(MAX_SAMPLES);
        acc_in   = s_axis_tvalid && s_axis_tready;
        out_free = !r_out_v || m_axis_tready;
    end

    assign s_axis_tready = (r_state == ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc_in) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (r_action == ACT_CLEAR || full) n_state = ST_MEDIAN;
                else n_state = ST_PUSH_RD;
            end
            ST_PUSH_RD: begin
                if (r_k != '0) n_state = ST_PUSH_CMP;
                else if (r_rep) n_state = ST_DN_LEFT;
                else n_state = ST_MEDIAN;
            end
            ST_PUSH_CMP: begin
                if (v_bp) n_state = ST_PUSH_RD;
                else if (r_rep) n_state = ST_DN_LEFT;
                else n_state = ST_MEDIAN;
            end
            ST_DN_LEFT: begin
                if (no_l) n_state = ST_MEDIAN;
                else n_state = ST_DN_RIGHT;
            end
            ST_DN_RIGHT: begin
                if (!no_r) n_state = ST_DN_CMP;
                else if (rd_bv) n_state = ST_DN_LEFT;
                else n_state = ST_MEDIAN;
            end
            ST_DN_CMP: begin
                if (lv_bv || rd_bv) n_state = ST_DN_LEFT;
                else n_state = ST_MEDIAN;
            end
            ST_MEDIAN: n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // heap memory accesses
    always_comb begin
        up_rd = 1'b0;
        lo_rd = 1'b0;
        hp_we = 1'b0;
        raddr = '0;
        waddr = r_k[AW-1:0];
        wdata = r_v;
        case (r_state)
            ST_IDLE: begin
                up_rd = 1'b1;
                lo_rd = 1'b1;
            end
            ST_PUSH_RD: begin
                if (r_k == '0) begin
                    hp_we = 1'b1;
                end else begin
                    up_rd = !r_hsel;
                    lo_rd = r_hsel;
                    raddr = parent[AW-1:0];
                end
            end
            ST_PUSH_CMP: begin
                hp_we = 1'b1;
                if (v_bp) wdata = rd;
            end
            ST_DN_LEFT: begin
                if (no_l) begin
                    hp_we = 1'b1;
                end else begin
                    up_rd = !r_hsel;
                    lo_rd = r_hsel;
                    raddr = lch[AW-1:0];
                end
            end
            ST_DN_RIGHT: begin
                if (no_r) begin
                    hp_we = 1'b1;
                    if (rd_bv) wdata = rd;
                end else begin
                    up_rd = !r_hsel;
                    lo_rd = r_hsel;
                    raddr = rch[AW-1:0];
                end
            end
            ST_DN_CMP: begin
                hp_we = 1'b1;
                if (lv_bv || rd_bv) wdata = lv_br ? r_l_val : rd;
            end
            ST_MEDIAN: begin
                up_rd = 1'b1;
            end
            default: ;
        endcase
    end

    assign up_we = hp_we && !r_hsel;
    assign lo_we = hp_we && r_hsel;

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_rep   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (acc_in) begin
                        r_action <= s_axis_tuser;
                        r_x      <= s_axis_tdata;
                    end
                end
                ST_DECIDE: begin
                    r_drop <= (r_action != ACT_CLEAR) && full;
                    if (r_action == ACT_CLEAR) begin
                        r_count <= '0;
                        r_rep   <= 1'b0;
                    end else if (full) begin
                        r_rep   <= 1'b0;
                    end else if (r_count == '0) begin
                        // first sample goes straight to the min-heap top
                        r_count <= CW'(1);
                        r_hsel  <= 1'b0;
                        r_k     <= '0;
                        r_v     <= r_x;
                        r_rep   <= 1'b0;
                    end else if (!r_count[0]) begin
                        // new count odd: the max-heap grows
                        r_count <= r_count + 1'b1;
                        r_hsel  <= 1'b1;
                        r_k     <= (AW+1)'(lo_sz);
                        if (r_x <= up_top) begin
                            r_v   <= r_x;
                            r_rep <= 1'b0;
                        end else begin
                            r_v     <= up_top;
                            r_rep   <= 1'b1;
                            r_rep_m <= (AW+1)'(up_sz);
                        end
                    end else begin
                        // new count even: the min-heap grows
                        r_count <= r_count + 1'b1;
                        r_hsel  <= 1'b0;
                        r_k     <= (AW+1)'(up_sz);
                        if (lo_sz != '0 && r_x <= lo_top) begin
                            r_v     <= lo_top;
                            r_rep   <= 1'b1;
                            r_rep_m <= (AW+1)'(lo_sz);
                        end else begin
                            r_v   <= r_x;
                            r_rep <= 1'b0;
                        end
                    end
                end
                ST_PUSH_RD: begin
                    if (r_k == '0 && r_rep) begin
                        r_hsel <= !r_hsel;
                        r_v    <= r_x;
                        r_m    <= r_rep_m;
                        r_rep  <= 1'b0;
                    end
                end
                ST_PUSH_CMP: begin
                    if (v_bp) begin
                        r_k <= parent;
                    end else if (r_rep) begin
                        // replace the other heap's top with the new sample
                        r_hsel <= !r_hsel;
                        r_k    <= '0;
                        r_v    <= r_x;
                        r_m    <= r_rep_m;
                        r_rep  <= 1'b0;
                    end
                end
                ST_DN_RIGHT: begin
                    r_l_val <= rd;
                    if (no_r && rd_bv) r_k <= lch[AW:0];
                end
                ST_DN_CMP: begin
                    if (lv_bv || rd_bv) r_k <= lv_br ? lch[AW:0] : rch[AW:0];
                end
                default: ;
            endcase

            // result beat valid
            if (r_state == ST_OUT && out_free) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // result register: min-heap top read in the median cycle
    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_total    <= TOTAL_W'(r_count);
            r_med      <= (r_count == '0) ? '0 : up_rd_data;
            r_res_drop <= r_drop;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {4'b0, r_total, r_med};
    assign m_axis_tuser  = r_res_drop;

    // count stays within capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SAMPLES)) else $error("count over capacity");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // one heap written at a time
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(up_we && lo_we)) else $error("both heaps written");

endmodule
